### rtl/utility_gradient_rate_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the utility gradient rate controller
// Shared concurrent assertion forms, clocked on clk with async reset.
// ----------------------------------------------------------------------------
`ifndef UTILITY_GRADIENT_RATE_CONTROLLER_MACROS_SVH
`define UTILITY_GRADIENT_RATE_CONTROLLER_MACROS_SVH

// Same-cycle implication
`define UGRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define UGRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ugrc_pkg.sv
// ----------------------------------------------------------------------------
// ugrc_pkg
// Widths, register indexes, state codes and helpers of the rate controller.
// ----------------------------------------------------------------------------
package ugrc_pkg;

    localparam int RATE_W     = 40;
    localparam int GRAD_W     = 32;
    localparam int GAIN_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int GRAD_FRAC  = 16;
    localparam int CHG_W      = 42;
    localparam int MAG_W      = 48;
    localparam int SUM_W      = 50;
    localparam int AMP_W      = 7;
    localparam int ALW_W      = 8;
    localparam int SWING_W    = 2;
    localparam int NUM_W      = 9;
    localparam int M_W        = 24;
    localparam int CFG_IDX_W  = 3;

    localparam int MUL_A_W    = 40;
    localparam int MUL_B_W    = 32;
    localparam int MUL_P_W    = 64;
    localparam int MUL_CNT_W  = 6;

    localparam logic [AMP_W-1:0]   AMPLIFIER_LIMIT = 7'd63;
    localparam logic [ALW_W-1:0]   ALLOWANCE_LIMIT = 8'd255;
    localparam logic [SWING_W-1:0] SWING_LIMIT     = 2'd2;
    localparam logic [RATE_W-1:0]  RATE_MAX        = {RATE_W{1'b1}};

    localparam logic [RATE_W-1:0] MIN_RATE_RST  = 40'd104857;
    localparam logic [RATE_W-1:0] MIN_STEP_RST  = 40'd209715;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 24'd1048576;
    localparam logic [FRAC_W-1:0] INIT_FRAC_RST = 16'd3277;
    localparam logic [FRAC_W-1:0] FRAC_STEP_RST = 16'd3932;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RATE  = 3'd0,
        CFG_MIN_STEP  = 3'd1,
        CFG_GAIN      = 3'd2,
        CFG_INIT_FRAC = 3'd3,
        CFG_FRAC_STEP = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_G,
        ST_SIGN,
        ST_MUL_A,
        ST_AMP,
        ST_MUL_M,
        ST_LIM,
        ST_MUL_L,
        ST_CLIP,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
        logic [MUL_CNT_W-1:0] nbits;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // Amplifier factor numerator (factor = num / 2) per amplifier step h
    function automatic logic [NUM_W-1:0] amp_num(input logic [AMP_W-1:0] h);
        logic [NUM_W-1:0] hw;
        hw = NUM_W'(h);
        if (h < 7'd6)
            return hw + 9'd2;
        else if (h < 7'd12)
            return (hw << 1) - 9'd4;
        else if (h < 7'd18)
            return (hw << 2) - 9'd28;
        else
            return (hw << 3) + hw - 9'd100;
    endfunction

endpackage

### rtl/ugrc_mul.sv
// ----------------------------------------------------------------------------
// ugrc_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ugrc_mul
    import ugrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mul_req_t             req,
    output mul_stat_t            stat,
    output logic [MUL_P_W-1:0]   product
);

`include "utility_gradient_rate_controller_macros.svh"

    logic [MUL_P_W-1:0]   a_reg, a_next;
    logic [MUL_B_W-1:0]   b_reg, b_next;
    logic [MUL_P_W-1:0]   acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // Load operands on start, else add and shift one bit per cycle
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = MUL_P_W'(req.a);
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = req.nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance operand and sum registers
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

    `UGRC_ASSERT_NOW(a_start_idle, clk, rst_n, req.start, !busy_reg, "mul start while busy")
    `UGRC_ASSERT_NEXT(a_done_ends, clk, rst_n, done_reg, !done_reg || req.start, "done held")

endmodule

### rtl/utility_gradient_rate_controller.sv
// ----------------------------------------------------------------------------
// utility_gradient_rate_controller
// Next sending rate from one utility gradient and the present rate.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  item     | item_valid / item_stall   | gradient, present_rate
//  result   | result_valid/result_stall | next_rate, applied_change, startup_active
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  A startup doubling beat is loaded at the edge it is taken; its result is
//  valid the next cycle.
//  Other beats go through four multiplier passes of 32, 9, 8 and 24 bits
//  and five decision steps (sign, amplifier, limit, clip, sum) before the
//  result load. One beat is worked at a time; the input stalls outside
//  idle, and in idle while the receiver stalls a valid result; a finished
//  result waits in the sum step while the receiver stalls, and the next
//  beat is taken only from idle. rst_n clears the control state at once;
//  config registers return to defaults; payload registers are not reset.
// ----------------------------------------------------------------------------
module utility_gradient_rate_controller
    import ugrc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [RATE_W-1:0]        cfg_data,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic signed [GRAD_W-1:0] gradient,
    input  logic [RATE_W-1:0]        present_rate,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [RATE_W-1:0]        next_rate,
    output logic signed [CHG_W-1:0]  applied_change,
    output logic                     startup_active
);

`include "utility_gradient_rate_controller_macros.svh"

    state_t state_reg, state_next;

    logic [RATE_W-1:0] min_rate_reg, min_step_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [FRAC_W-1:0] init_frac_reg, frac_step_reg;

    logic               startup_reg;
    logic [CHG_W-1:0]   last_change_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic [ALW_W-1:0]   alw_reg;
    logic [SWING_W-1:0] swing_reg;

    logic [RATE_W-1:0] cur_reg;
    logic              gneg_reg;
    logic              neg_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  limit_reg;
    logic [M_W-1:0]    m_reg;

    logic              result_valid_reg;
    logic [RATE_W-1:0] next_rate_reg;
    logic [CHG_W-1:0]  applied_reg;
    logic              startup_out_reg;

    mul_req_t           mul_req;
    mul_stat_t          mul_stat;
    logic [MUL_P_W-1:0] mul_p;

    logic              out_free, accept, startup_go, gneg_in;
    logic [GRAD_W-1:0] gmag_in;
    logic [RATE_W:0]   dbl;
    logic [RATE_W-1:0] dbl_sat;
    logic              prev_pos;
    logic              mag_nz, pos0, flip0;
    logic [AMP_W-1:0]  h_eff;
    logic              pos1;
    logic [AMP_W:0]    amp_inc;
    logic              exceed;
    logic [MAG_W-1:0]  magf;
    logic              negf, posf, flip2;
    logic [SUM_W-1:0]  s_cur, s_mag, sum, clamped;
    logic              below, over;
    logic [RATE_W-1:0] fin_rate;
    logic              out_load;
    logic              in_mul_wait;

    ugrc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .stat    (mul_stat),
        .product (mul_p)
    );

    // Input decode and startup doubling
    assign out_free   = !result_valid_reg || !result_stall;
    assign accept     = item_valid && !item_stall;
    assign gneg_in    = gradient[GRAD_W-1];
    assign gmag_in    = gneg_in ? (~gradient + 1'b1) : gradient;
    assign startup_go = startup_reg && !gneg_in && (gradient != '0);
    assign dbl        = {present_rate, 1'b0};
    assign dbl_sat    = dbl[RATE_W] ? RATE_MAX : dbl[RATE_W-1:0];
    assign prev_pos   = !last_change_reg[CHG_W-1] && (last_change_reg != '0);

    // Sign step after scaling the gradient
    assign mag_nz = (mag_reg != '0);
    assign pos0   = !gneg_reg && mag_nz;
    assign flip0  = (pos0 != prev_pos);
    assign h_eff  = flip0 ? '0 : amp_reg;

    // Amplifier step after applying the factor
    assign pos1    = !neg_reg && mag_nz;
    assign amp_inc = {1'b0, amp_reg} + ((amp_reg < 7'd6) ? 8'd1 : 8'd2);

    // Clip against the allowed fraction of the rate
    assign exceed = (cur_reg != '0) ? (mag_reg > limit_reg) : (m_reg[M_W-1:FRAC_W] == '0);
    assign magf   = exceed ? limit_reg : mag_reg;
    assign negf   = neg_reg && (magf != '0);
    assign posf   = !negf && (magf != '0);
    assign flip2  = (posf != prev_pos);

    // Apply the change, floor and saturate
    assign s_cur    = SUM_W'(cur_reg);
    assign s_mag    = SUM_W'(mag_reg);
    assign sum      = neg_reg ? (s_cur - s_mag) : (s_cur + s_mag);
    assign below    = $signed(sum) < $signed(SUM_W'(min_rate_reg));
    assign clamped  = below ? SUM_W'(min_rate_reg) : sum;
    assign over     = (clamped[SUM_W-1:RATE_W] != '0);
    assign fin_rate = over ? RATE_MAX : clamped[RATE_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept && !startup_go) state_next = ST_MUL_G;
            ST_MUL_G: if (mul_stat.done) state_next = ST_SIGN;
            ST_SIGN:  state_next = ST_MUL_A;
            ST_MUL_A: if (mul_stat.done) state_next = ST_AMP;
            ST_AMP:   state_next = ST_MUL_M;
            ST_MUL_M: if (mul_stat.done) state_next = ST_LIM;
            ST_LIM:   state_next = ST_MUL_L;
            ST_MUL_L: if (mul_stat.done) state_next = ST_CLIP;
            ST_CLIP:  state_next = ST_SUM;
            ST_SUM:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: stall, multiplier launch, result load
    always_comb
    begin
        item_stall    = 1'b1;
        out_load      = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        mul_req.nbits = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall    = !out_free;
                out_load      = accept && startup_go;
                mul_req.start = accept && !startup_go;
                mul_req.a     = MUL_A_W'(gain_reg);
                mul_req.b     = gmag_in;
                mul_req.nbits = MUL_CNT_W'(GRAD_W);
            end
            ST_SIGN:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = mag_reg[MUL_A_W-1:0];
                mul_req.b     = MUL_B_W'(amp_num(h_eff));
                mul_req.nbits = MUL_CNT_W'(NUM_W);
            end
            ST_AMP:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(frac_step_reg);
                mul_req.b     = MUL_B_W'(alw_reg);
                mul_req.nbits = MUL_CNT_W'(ALW_W);
            end
            ST_LIM:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = cur_reg;
                mul_req.b     = MUL_B_W'(m_reg);
                mul_req.nbits = MUL_CNT_W'(M_W);
            end
            ST_SUM:   out_load = out_free;
            default:  item_stall = 1'b1;
        endcase
    end

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            startup_reg      <= 1'b1;
            last_change_reg  <= '0;
            amp_reg          <= '0;
            alw_reg          <= '0;
            swing_reg        <= '0;
            result_valid_reg <= 1'b0;
            min_rate_reg     <= MIN_RATE_RST;
            min_step_reg     <= MIN_STEP_RST;
            gain_reg         <= GAIN_RST;
            init_frac_reg    <= INIT_FRAC_RST;
            frac_step_reg    <= FRAC_STEP_RST;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MIN_RATE:  min_rate_reg  <= cfg_data;
                    CFG_MIN_STEP:  min_step_reg  <= cfg_data;
                    CFG_GAIN:      gain_reg      <= cfg_data[GAIN_W-1:0];
                    CFG_INIT_FRAC: init_frac_reg <= cfg_data[FRAC_W-1:0];
                    CFG_FRAC_STEP: frac_step_reg <= cfg_data[FRAC_W-1:0];
                    default:       ;
                endcase
            end

            // Result handshake
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && startup_go)
                        last_change_reg <= CHG_W'(present_rate);
                    else if (accept)
                        startup_reg <= 1'b0;
                end
                ST_SIGN:
                begin
                    if (flip0)
                    begin
                        amp_reg <= '0;
                        alw_reg <= '0;
                        if (swing_reg < SWING_LIMIT)
                            swing_reg <= swing_reg + 1'b1;
                    end
                end
                ST_AMP:
                begin
                    if (pos1 == prev_pos)
                    begin
                        if (swing_reg == '0)
                            amp_reg <= (amp_inc > {1'b0, AMPLIFIER_LIMIT}) ?
                                       AMPLIFIER_LIMIT : amp_inc[AMP_W-1:0];
                        else
                            swing_reg <= swing_reg - 1'b1;
                    end
                end
                ST_CLIP:
                begin
                    if (flip2)
                    begin
                        amp_reg <= '0;
                        alw_reg <= '0;
                    end
                    else if (exceed)
                    begin
                        if (alw_reg < ALLOWANCE_LIMIT)
                            alw_reg <= alw_reg + 1'b1;
                    end
                    else if (alw_reg != '0)
                        alw_reg <= alw_reg - 1'b1;
                end
                ST_SUM:
                begin
                    if (out_free)
                        last_change_reg <= CHG_W'(fin_rate) - CHG_W'(cur_reg);
                end
                default: ;
            endcase
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg  <= present_rate;
                gneg_reg <= gneg_in;
            end
            ST_MUL_G:
                if (mul_stat.done)
                    mag_reg <= MAG_W'(mul_p[GRAD_FRAC+RATE_W-1:GRAD_FRAC]);
            ST_SIGN:
                neg_reg <= gneg_reg && mag_nz;
            ST_MUL_A:
                if (mul_stat.done)
                    mag_reg <= mul_p[MAG_W:1];
            ST_MUL_M:
                if (mul_stat.done)
                    m_reg <= M_W'(init_frac_reg) + mul_p[M_W-1:0];
            ST_MUL_L:
                if (mul_stat.done)
                    limit_reg <= mul_p[MAG_W+FRAC_W-1:FRAC_W];
            ST_CLIP:
            begin
                neg_reg <= negf;
                mag_reg <= (magf < MAG_W'(min_step_reg)) ? MAG_W'(min_step_reg) : magf;
            end
            default: ;
        endcase

        if (out_load)
        begin
            if (state_reg == ST_IDLE)
            begin
                next_rate_reg   <= dbl_sat;
                applied_reg     <= CHG_W'(dbl_sat) - CHG_W'(present_rate);
                startup_out_reg <= 1'b1;
            end
            else
            begin
                next_rate_reg   <= fin_rate;
                applied_reg     <= CHG_W'(fin_rate) - CHG_W'(cur_reg);
                startup_out_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready      = 1'b1;
    assign result_valid   = result_valid_reg;
    assign next_rate      = next_rate_reg;
    assign applied_change = $signed(applied_reg);
    assign startup_active = startup_out_reg;

    // Multiplier may only run in one of the wait states
    assign in_mul_wait = (state_reg == ST_MUL_G) || (state_reg == ST_MUL_A) ||
                         (state_reg == ST_MUL_M) || (state_reg == ST_MUL_L);

    `UGRC_ASSERT_NOW(a_busy_state, clk, rst_n, mul_stat.busy, in_mul_wait, "mul busy outside wait")
    `UGRC_ASSERT_NOW(a_no_startup, clk, rst_n, state_reg != ST_IDLE, !startup_reg, "startup set while working")
    `UGRC_ASSERT_NOW(a_amp_limit, clk, rst_n, 1'b1, amp_reg <= AMPLIFIER_LIMIT, "amplifier above limit")
    `UGRC_ASSERT_NEXT(a_load_valid, clk, rst_n, out_load, result_valid_reg, "result lost on load")

endmodule

### tb/tb_utility_gradient_rate_controller.sv
// ----------------------------------------------------------------------------
// Testbench for utility_gradient_rate_controller
// Drives gradient/rate beats with random gaps and result back-pressure,
// predicts every next rate with an internal copy of the control state and
// compares each result beat field by field, across several register settings.
// ----------------------------------------------------------------------------
module tb_utility_gradient_rate_controller
    import ugrc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [CHG_W-1:0]  delta;
        logic              boot;
    } rate_result_t;

    typedef struct {
        logic [GRAD_W-1:0] grad;
        logic [RATE_W-1:0] rate;
        bit                pinned;
        rate_result_t      res;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [RATE_W-1:0]        cfg_data;
    logic                     item_valid;
    logic                     item_stall;
    logic signed [GRAD_W-1:0] gradient;
    logic [RATE_W-1:0]        present_rate;
    logic                     result_valid;
    logic                     result_stall;
    logic [RATE_W-1:0]        next_rate;
    logic signed [CHG_W-1:0]  applied_change;
    logic                     startup_active;

    // typed expectation travels with the beat
    logic         pin_on;
    rate_result_t pin_res;

    rate_result_t rate_q[$];
    stim_row_t    rows[$];
    int           mismatches = 0;
    int           cycles = 0;
    bit           hold_req = 1'b0;

    // predictor copy of registers and control state
    logic [RATE_W-1:0] floor_rate = MIN_RATE_RST;
    logic [RATE_W-1:0] step_rate  = MIN_STEP_RST;
    logic [GAIN_W-1:0] gain       = GAIN_RST;
    logic [FRAC_W-1:0] base_frac  = INIT_FRAC_RST;
    logic [FRAC_W-1:0] frac_inc   = FRAC_STEP_RST;
    bit                in_boot    = 1'b1;
    longint            prev_delta = 0;
    int unsigned       amp_h      = 0;
    int unsigned       allow_cnt  = 0;
    int unsigned       swing      = 0;

    utility_gradient_rate_controller u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic rate_result_t decide_rate(input logic [GRAD_W-1:0] g,
                                                 input logic [RATE_W-1:0] cur_in);
        logic [GRAD_W-1:0] gm;
        longint unsigned   cur, gmag, mag, num, m, lim, nxt;
        longint            chg, sum;
        bit                gneg, prev_pos, neg, pos;
        int unsigned       h;
        rate_result_t      r;
        cur = cur_in;
        gneg = g[GRAD_W-1];
        gm = gneg ? (~g + 32'd1) : g;
        gmag = gm;
        prev_pos = prev_delta > 0;
        // startup doubling
        if (in_boot && !gneg && gmag != 0)
        begin
            nxt = cur << 1;
            if (nxt > RATE_MAX) nxt = RATE_MAX;
            prev_delta = cur;
            r.rate = nxt[RATE_W-1:0];
            r.delta = CHG_W'(nxt - cur);
            r.boot = 1'b1;
            return r;
        end
        in_boot = 1'b0;
        // scale gradient, reset amplifier on direction flip
        mag = (longint'(gain) * gmag) >> GRAD_FRAC;
        neg = gneg && mag != 0;
        pos = !gneg && mag != 0;
        if (pos != prev_pos)
        begin
            amp_h = 0;
            allow_cnt = 0;
            if (swing < 2) swing++;
        end
        h = amp_h;
        if (h < 6) num = h + 2;
        else if (h < 12) num = 2 * h - 4;
        else if (h < 18) num = 4 * h - 28;
        else num = 9 * h - 100;
        mag = (mag * num) >> 1;
        pos = !neg && mag != 0;
        if (pos == prev_pos)
        begin
            if (swing == 0)
            begin
                h = amp_h + (amp_h < 6 ? 1 : 2);
                amp_h = h > AMPLIFIER_LIMIT ? AMPLIFIER_LIMIT : h;
            end
            if (swing > 0) swing--;
        end
        // limit to allowed fraction of the rate
        m = longint'(base_frac) + longint'(allow_cnt) * longint'(frac_inc);
        lim = m * (cur >> 16) + ((m * (cur & 64'hFFFF)) >> 16);
        if (cur != 0 ? (mag > lim) : (m < 65536))
        begin
            if (allow_cnt < ALLOWANCE_LIMIT) allow_cnt++;
            mag = lim;
        end
        else if (allow_cnt > 0)
            allow_cnt--;
        if (mag == 0) neg = 1'b0;
        pos = !neg && mag != 0;
        if (pos != prev_pos)
        begin
            amp_h = 0;
            allow_cnt = 0;
        end
        // minimum step, floor and saturate
        if (mag < step_rate) mag = step_rate;
        chg = neg ? -longint'(mag) : longint'(mag);
        sum = longint'(cur) + chg;
        if (sum < longint'(floor_rate)) sum = longint'(floor_rate);
        nxt = sum;
        if (nxt > RATE_MAX) nxt = RATE_MAX;
        prev_delta = longint'(nxt) - longint'(cur);
        r.rate = nxt[RATE_W-1:0];
        r.delta = CHG_W'(nxt - cur);
        r.boot = 1'b0;
        return r;
    endfunction

    // track register writes, predict accepted beats, check result beats
    always @(posedge clk)
    begin
        rate_result_t want;
        rate_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_RATE:  floor_rate = cfg_data;
                    CFG_MIN_STEP:  step_rate  = cfg_data;
                    CFG_GAIN:      gain       = cfg_data[GAIN_W-1:0];
                    CFG_INIT_FRAC: base_frac  = cfg_data[FRAC_W-1:0];
                    CFG_FRAC_STEP: frac_inc   = cfg_data[FRAC_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                want = decide_rate(gradient, present_rate);
                rate_q.push_back(pin_on ? pin_res : want);
            end
            if (result_valid && !result_stall)
            begin
                got = '{next_rate, applied_change, startup_active};
                if (rate_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat rate=%0d", next_rate);
                end
                else
                begin
                    want = rate_q.pop_front();
                    if (got.rate !== want.rate || got.delta !== want.delta
                        || got.boot !== want.boot)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: rate %0d/%0d change %0d/%0d startup %0b/%0b",
                                     want.rate, got.rate, $signed(want.delta),
                                     $signed(got.delta), want.boot, got.boot);
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        int pick;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (pick < 55)
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else if (pick < 62)
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(20, 200)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b1;
                repeat (pick < 95 ? $urandom_range(1, 4) : $urandom_range(20, 90))
                    @(posedge clk);
            end
        end
    end

    task automatic idle_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 50) gap = 0;
        else if (pick < 85) gap = $urandom_range(1, 3);
        else if (pick < 97) gap = $urandom_range(4, 15);
        else gap = $urandom_range(30, 120);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_beat(input stim_row_t row);
        item_valid   <= 1'b1;
        gradient     <= row.grad;
        present_rate <= row.rate;
        pin_on       <= row.pinned;
        pin_res      <= row.res;
        do @(posedge clk); while (item_stall);
        idle_gap();
    endtask

    task automatic add_row(input logic [GRAD_W-1:0] g, input logic [RATE_W-1:0] r);
        stim_row_t row;
        row.grad = g;
        row.rate = r;
        row.pinned = 1'b0;
        row.res = '0;
        rows.push_back(row);
    endtask

    task automatic add_pinned(input logic [GRAD_W-1:0] g, input logic [RATE_W-1:0] r,
                              input rate_result_t res);
        stim_row_t row;
        row.grad = g;
        row.rate = r;
        row.pinned = 1'b1;
        row.res = res;
        rows.push_back(row);
    endtask

    // drain results and let the datapath settle before touching registers
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        wait (rate_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one write beat, then valid is taken low again
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [RATE_W-1:0] fl, input logic [RATE_W-1:0] st,
                             input logic [GAIN_W-1:0] gn, input logic [FRAC_W-1:0] bf,
                             input logic [FRAC_W-1:0] fi);
        write_reg(CFG_MIN_RATE, fl);
        write_reg(CFG_MIN_STEP, st);
        write_reg(CFG_GAIN, RATE_W'(gn));
        write_reg(CFG_INIT_FRAC, RATE_W'(bf));
        write_reg(CFG_FRAC_STEP, RATE_W'(fi));
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return '0;
        if (pick < 10) return RATE_MAX;
        if (pick < 25) return RATE_W'({$urandom(), $urandom()});
        return RATE_W'($urandom_range(0, 32'h7FFF_FFFF)) << $urandom_range(0, 8);
    endfunction

    function automatic logic [GRAD_W-1:0] pick_grad(input bit neg);
        logic [GRAD_W-1:0] mag;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return $urandom();
        if (pick < 15) return '0;
        mag = $urandom_range(1, 32'h0040_0000) >> $urandom_range(0, 20);
        if (mag == 0) mag = 1;
        return neg ? (~mag + 32'd1) : mag;
    endfunction

    // random part: runs of one sign with random content, some noise
    task automatic random_phase(input int count);
        stim_row_t row;
        int sent;
        int run;
        bit neg;
        logic [RATE_W-1:0] base;
        sent = 0;
        while (sent < count)
        begin
            run = $urandom_range(0, 9) < 7 ? $urandom_range(1, 30) : 1;
            neg = 1'($urandom_range(0, 1));
            base = pick_rate();
            repeat (run)
            begin
                row.grad = pick_grad(neg);
                row.rate = $urandom_range(0, 3) == 0 ? pick_rate() : base;
                row.pinned = 1'b0;
                row.res = '0;
                send_beat(row);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        gradient     = '0;
        present_rate = '0;
        pin_on       = 1'b0;
        pin_res      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // startup doubling, saturation, zero rate, then end of startup
        add_pinned(32'd1, 40'd1000, '{40'd1000 * 2, 42'd1000, 1'b1});
        add_pinned(32'h7FFF_FFFF, RATE_MAX, '{RATE_MAX, 42'd0, 1'b1});
        add_pinned(32'd1, 40'd0, '{40'd0, 42'd0, 1'b1});
        add_row(32'd0, 40'd5000000);
        add_row(32'h8000_0000, 40'd0);
        add_row(32'h8000_0000, RATE_MAX);
        add_row(32'h7FFF_FFFF, RATE_MAX);
        add_row(32'h7FFF_FFFF, 40'd0);
        add_row(32'd0, 40'd0);
        add_row(32'hFFFF_FFFF, 40'd123456789);
        repeat (6) add_row(32'h0001_0000, 40'd10000000);
        repeat (3) add_row(32'hFFFF_0000, 40'd10000000);
        repeat (4) add_row(32'h0020_0000, 40'd1000000000);
        add_row(32'h5555_AAAA, 40'hAA_5555_AAAA);
        foreach (rows[i]) send_beat(rows[i]);

        // defaults, with the long receiver hold while beats keep coming
        wait_idle();
        write_reg(CFG_UNUSED_IDX, RATE_MAX);
        hold_req = 1'b1;
        random_phase(200);
        wait_idle();

        // all registers at zero
        load_regs('0, '0, '0, '0, '0);
        random_phase(150);
        wait_idle();

        // all registers at their maximum
        load_regs(RATE_MAX, RATE_MAX, '1, '1, '1);
        random_phase(100);
        wait_idle();

        // small floors, strong gain: amplifier and allowance saturate
        load_regs(40'd1, 40'd1, 24'hFF_FFFF, 16'd1, 16'd1);
        random_phase(250);
        wait_idle();

        // random settings
        repeat (3)
        begin
            load_regs(RATE_W'($urandom_range(0, 1 << 24)), RATE_W'($urandom_range(0, 1 << 22)),
                      GAIN_W'($urandom()), FRAC_W'($urandom()), FRAC_W'($urandom()));
            random_phase(150);
            wait_idle();
        end

        if (mismatches == 0 && rate_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/ugrc_pkg.sv
rtl/ugrc_mul.sv
rtl/utility_gradient_rate_controller.sv
tb/tb_utility_gradient_rate_controller.sv
